### hw/rtl/sm3_pkg.sv
package sm3_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [31:0] PAD_BIT = 32'h80000000;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                3'd0: v = 32'h7380166f;
                3'd1: v = 32'h4914b2b9;
                3'd2: v = 32'h172442d7;
                3'd3: v = 32'hda8a0600;
                3'd4: v = 32'ha96f30bc;
                3'd5: v = 32'h163138aa;
                3'd6: v = 32'he38dee4d;
                default: v = 32'hb0fb0e4e;
            endcase
            return v;
        end
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            return d[63:32];
        end
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
    endfunction

endpackage

### hw/rtl/sm3_hash_engine_unit.sv
// channel | dir | tdata fields (low bit up)         | tuser (low bit up) / tlast
// s_axis  | in  | message_word[31:0]                | tuser bytes_valid[2:0], start_of_message[3]
//         |     |                                   | tlast last_of_message
// m_axis  | out | digest_word[31:0]                 | tuser digest_index[2:0]; tlast digest_last
// a plain word is only stored in the window; the 16th word of a block starts the 64 rounds, then the fold
// one shared round unit does one sm3 round per cycle
// a last word pads: up to two blocks, then 8 digest words
// s_axis_tready is low while a block compresses, and from a last word until its digest is taken
// rst_n clears control state and reloads the iv; window and round words are not reset
module sm3_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // message_word
    input  logic [3:0]  s_axis_tuser,   // bytes_valid[2:0], start_of_message
    input  logic        s_axis_tlast,   // last_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // digest_index
    output logic        m_axis_tlast    // digest_last
);
    import sm3_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] cv_reg [8];
    logic [31:0] r_reg [8];
    logic [31:0] w_reg [16];
    logic [3:0]  cnt_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        pad_last_reg;   // the pad phase has already placed the length words
    logic [2:0]  out_idx_reg;
    logic        pad_active_reg; // message finishing: padding in progress
    logic        wrap_reg;       // pad marker sits past slot 13: length goes in the next block

    // word to push this cycle (from input or padding)
    logic        push;
    logic [31:0] push_word;
    logic        s_acc;
    logic        m_acc;
    logic [2:0]  nb;
    logic [31:0] masked;
    logic        start_in;
    logic        extra_pad;    // last word was full: 0x80 word still owed
    logic        extra_reg;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign m_acc  = m_axis_tvalid && m_axis_tready;
    assign start_in = s_axis_tuser[3];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = cv_reg[out_idx_reg];
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

    always_comb
    begin
        nb = s_axis_tuser[2:0];
        if (nb > 3'd4 || !s_axis_tlast)
        begin
            nb = 3'd4;
        end
        case (nb)
            3'd0: masked = 32'h0;
            3'd1: masked = {s_axis_tdata[31:24], 24'h0};
            3'd2: masked = {s_axis_tdata[31:16], 16'h0};
            3'd3: masked = {s_axis_tdata[31:8], 8'h0};
            default: masked = s_axis_tdata;
        endcase
        if (nb != 3'd4)
        begin
            masked = masked | (PAD_BIT >> {nb[1:0], 3'b000});
        end
        extra_pad = s_axis_tlast && (nb == 3'd4);
    end

    // round datapath, shared by all 64 rounds
    logic [3:0]  j4;
    logic [31:0] wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
    always_comb
    begin
        j4  = rnd_reg[3:0];
        wj  = w_reg[j4];
        wj4 = w_reg[j4 + 4'd4];
        tj  = (rnd_reg < 6'd16) ? T_LOW : T_HIGH;
        a12 = {r_reg[0][19:0], r_reg[0][31:20]};
        ss1 = a12 + r_reg[4] + rotl32(tj, rnd_reg[4:0]);
        ss1 = {ss1[24:0], ss1[31:25]};
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (wj ^ wj4);
        tt2 = gg + r_reg[7] + ss1 + wj;
        wn  = perm1(wj ^ w_reg[j4 + 4'd7] ^ rotl32(w_reg[j4 + 4'd13], 5'd15))
              ^ rotl32(w_reg[j4 + 4'd3], 5'd7) ^ w_reg[j4 + 4'd10];
    end

    // next state and push word; pad words: 0x80 word if owed, zeros up to slot 14, then length high / low
    always_comb
    begin
        state_next = state_reg;
        push = 1'b0;
        push_word = 32'h0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    push = 1'b1;
                    push_word = s_axis_tlast ? masked : s_axis_tdata;
                    if ((start_in ? 4'd0 : cnt_reg) == 4'd15)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push = 1'b1;
                if (extra_reg)
                begin
                    push_word = PAD_BIT;
                end
                else if (cnt_reg == 4'd14 && !wrap_reg)
                begin
                    push_word = len_reg[63:32];
                end
                else if (cnt_reg == 4'd15 && !wrap_reg)
                begin
                    push_word = len_reg[31:0];
                end
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (pad_last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (extra_reg || cnt_reg != 4'd0 || pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (m_acc && out_idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= 4'd0;
            len_reg        <= 64'd0;
            rnd_reg        <= 6'd0;
            pad_last_reg   <= 1'b0;
            pad_active_reg <= 1'b0;
            wrap_reg       <= 1'b0;
            extra_reg      <= 1'b0;
            out_idx_reg    <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= iv_word(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_acc)
            begin
                if (start_in)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= iv_word(3'(i));
                    end
                end
                len_reg <= (start_in ? 64'd0 : len_reg) + {58'd0, nb, 3'b000};
                extra_reg <= extra_pad;
                pad_active_reg <= s_axis_tlast;
                wrap_reg <= s_axis_tlast && !extra_pad
                            && ((start_in ? 4'd0 : cnt_reg) >= 4'd14);
            end
            if (push)
            begin
                cnt_reg <= ((state_reg == ST_IDLE && start_in) ? 4'd0 : cnt_reg) + 4'd1;
                if (state_reg == ST_PAD)
                begin
                    extra_reg <= 1'b0;
                    if (extra_reg)
                    begin
                        wrap_reg <= (cnt_reg >= 4'd14);
                    end
                    if (cnt_reg == 4'd15 && !extra_reg && !wrap_reg)
                    begin
                        pad_last_reg <= 1'b1;
                    end
                end
            end
            if (state_reg == ST_ROUND)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (state_reg == ST_FOLD)
            begin
                wrap_reg <= 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    cv_reg[i] <= cv_reg[i] ^ r_reg[i];
                end
            end
            if (state_reg == ST_EMIT && m_acc)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= iv_word(3'(i));
                    end
                    len_reg        <= 64'd0;
                    cnt_reg        <= 4'd0;
                    pad_last_reg   <= 1'b0;
                    pad_active_reg <= 1'b0;
                end
            end
        end
    end

    // payload: window and round words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            w_reg[(state_reg == ST_IDLE && start_in) ? 4'd0 : cnt_reg] <= push_word;
        end
        if (state_next == ST_ROUND && state_reg != ST_ROUND)
        begin
            for (int i = 0; i < 8; i++)
            begin
                r_reg[i] <= cv_reg[i];
            end
        end
        if (state_reg == ST_ROUND)
        begin
            r_reg[3] <= r_reg[2];
            r_reg[2] <= {r_reg[1][22:0], r_reg[1][31:23]};
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= {r_reg[5][12:0], r_reg[5][31:13]};
            r_reg[5] <= r_reg[4];
            r_reg[4] <= perm0(tt2);
            w_reg[j4] <= wn;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while emitting");
    a_rounds_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> (rnd_reg == 6'd0)) else $error("round count off");
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && !m_axis_tlast) |=> (m_axis_tvalid && $past(out_idx_reg) + 3'd1 == out_idx_reg))
        else $error("digest order");
endmodule

### sim/sm3_hash_engine_unit_test.sv
module sm3_hash_engine_unit_test;

    import sm3_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;   // bytes_valid[2:0], start_of_message
    logic        s_axis_tlast;   // last_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic [2:0]  m_axis_tuser;   // digest_index
    logic        m_axis_tlast;   // digest_last

    sm3_hash_engine_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // digest words still to come, oldest first
    digest_beat_t digest_q[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           words_sent  = 0;
    bit           quiet_sender = 0;
    bit           quiet_receiver = 0;
    int           rx_stall = 0;

    // shadow copy of the hash state
    logic [31:0] sh_cv [8];
    logic [31:0] sh_win [16];
    logic [3:0]  sh_count;
    logic [63:0] sh_bits;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rot_left(logic [31:0] x, int n);
        n = n % 32;
        if (n == 0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] mix_p0(logic [31:0] x);
        return x ^ rot_left(x, 9) ^ rot_left(x, 17);
    endfunction

    function automatic logic [31:0] mix_p1(logic [31:0] x);
        return x ^ rot_left(x, 15) ^ rot_left(x, 23);
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            sh_cv[i] = iv_word(i[2:0]);
        sh_count = '0;
        sh_bits  = '0;
    endtask

    // 64 rounds over the window, folded into the chaining value
    task automatic compress_window();
        logic [31:0] r [8];
        logic [31:0] wj, tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
        for (int i = 0; i < 8; i++)
            r[i] = sh_cv[i];
        for (int j = 0; j < 64; j++)
        begin
            wj  = sh_win[j % 16];
            tj  = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
            a12 = rot_left(r[0], 12);
            ss1 = rot_left(a12 + r[4] + rot_left(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end
            else
            begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (wj ^ sh_win[(j + 4) % 16]);
            tt2 = gg + r[7] + ss1 + wj;
            r[3] = r[2];
            r[2] = rot_left(r[1], 9);
            r[1] = r[0];
            r[0] = tt1;
            r[7] = r[6];
            r[6] = rot_left(r[5], 19);
            r[5] = r[4];
            r[4] = mix_p0(tt2);
            wn = mix_p1(wj ^ sh_win[(j + 7) % 16] ^ rot_left(sh_win[(j + 13) % 16], 15))
                 ^ rot_left(sh_win[(j + 3) % 16], 7) ^ sh_win[(j + 10) % 16];
            sh_win[j % 16] = wn;
        end
        for (int i = 0; i < 8; i++)
            sh_cv[i] ^= r[i];
    endtask

    task automatic load_word(logic [31:0] w);
        sh_win[sh_count] = w;
        sh_count = sh_count + 4'd1;
        if (sh_count == 4'd0)
            compress_window();
    endtask

    // shadow hash update for one accepted input word; a last word queues the expected digest words
    task automatic predict_digest(logic [31:0] w, logic [2:0] nbytes, bit sop, bit eop);
        logic [31:0] keep;
        digest_beat_t beat;
        if (sop)
            restart_hash();
        if (nbytes > 3'd4 || !eop)
            nbytes = 3'd4;
        sh_bits = sh_bits + 64'(nbytes) * 64'd8;
        if (!eop)
        begin
            load_word(w);
            return;
        end
        keep = (nbytes == 3'd0) ? 32'h0 : ~(32'hffffffff >> (8 * nbytes));
        w = w & keep;
        if (nbytes < 3'd4)
            load_word(w | (PAD_BIT >> (8 * nbytes)));
        else
        begin
            load_word(w);
            load_word(PAD_BIT);
        end
        while (sh_count != 4'd14)
            load_word(32'h0);
        load_word(sh_bits[63:32]);
        load_word(sh_bits[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            beat.word  = sh_cv[k];
            beat.index = k[2:0];
            beat.last  = (k == 7);
            digest_q.push_back(beat);
        end
        restart_hash();
    endtask

    // one word on the slave side, with a random gap ahead of it
    task automatic send_word(logic [31:0] w, logic [2:0] nbytes, bit sop, bit eop);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= {sop, nbytes};
        s_axis_tlast  <= eop;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_digest(w, nbytes, sop, eop);
        words_sent++;
    endtask

    // whole message of n words; tail byte count picks the last word's size
    task automatic send_message(int n, logic [2:0] tail, bit sop);
        for (int i = 0; i < n; i++)
            send_word($urandom, (i == n - 1) ? tail : 3'd4, sop && (i == 0), i == n - 1);
    endtask

    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        wait (digest_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // receiver with a random stall drawn per digest word
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                rx_stall = quiet_receiver ? 0 : $urandom_range(0, 14);
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // digest checker
    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_beat = digest_q.pop_front();
                if (m_axis_tdata !== exp_beat.word)
                begin
                    $error("digest_word expected %h got %h", exp_beat.word, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== exp_beat.index)
                begin
                    $error("digest_index expected %0d got %0d", exp_beat.index, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== exp_beat.last)
                begin
                    $error("digest_last expected %0d got %0d", exp_beat.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_known_vectors();
        // "abc", then the empty message twice, the second without a start flag
        send_word(32'h61626300, 3'd3, 1'b1, 1'b1);
        send_word(32'hffffffff, 3'd0, 1'b1, 1'b1);
        send_word(32'h00000000, 3'd0, 1'b0, 1'b1);
        // "abcd" x16: exactly one full block plus a padding block
        for (int i = 0; i < 16; i++)
            send_word(32'h61626364, 3'd4, i == 0, i == 15);
        drain_digests();
    endtask

    task automatic test_edge_words();
        // all-ones with tail sizes 7, 5 and 1, all-zeros with 2; oversize counts too
        send_word(32'hffffffff, 3'd7, 1'b1, 1'b1);
        send_word(32'hffffffff, 3'd5, 1'b1, 1'b1);
        send_word(32'hffffffff, 3'd1, 1'b1, 1'b1);
        send_word(32'h00000000, 3'd2, 1'b1, 1'b1);
        // short count on a non-last word still means four bytes
        send_word(32'h12345678, 3'd1, 1'b1, 1'b0);
        send_word(32'h9abcdef0, 3'd6, 1'b0, 1'b0);
        send_word(32'hdeadbeef, 3'd4, 1'b0, 1'b1);
        // start flag in mid-message drops the partial block
        send_word(32'h11111111, 3'd4, 1'b1, 1'b0);
        send_word(32'h22222222, 3'd4, 1'b0, 1'b0);
        send_word(32'h33333333, 3'd2, 1'b1, 1'b1);
        drain_digests();
    endtask

    task automatic test_block_boundaries();
        // 14 and 15 words force the length into a second block
        quiet_sender = 1;
        quiet_receiver = 1;
        send_message(14, 3'd4, 1'b1);
        send_message(15, 3'd3, 1'b1);
        quiet_sender = 0;
        quiet_receiver = 0;
        send_message(13, 3'd4, 1'b1);
        drain_digests();
    endtask

    task automatic test_random_messages();
        int n, pick;
        logic [2:0] tail;
        while (words_sent < 350)
        begin
            pick = $urandom_range(0, 99);
            quiet_sender   = ($urandom_range(0, 5) == 0);
            quiet_receiver = ($urandom_range(0, 5) == 0);
            tail = 3'($urandom_range(0, 7));
            if (pick < 80)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
                                                 : $urandom_range(1, 20);
                send_message(n, tail, $urandom_range(0, 4) != 0);
            end
            else if (pick < 90)
            begin
                // message that starts with a start flag and ends in a full four-byte word
                send_message($urandom_range(1, 20), 3'd4, 1'b1);
            end
            else
                send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            if ($urandom_range(0, 29) == 0)
                drain_digests();
        end
        send_word($urandom, 3'd4, 1'b0, 1'b1);
        quiet_sender = 0;
        quiet_receiver = 0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        restart_hash();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_known_vectors();
        test_edge_words();
        test_block_boundaries();
        test_random_messages();
        drain_digests();
        repeat (200) @(posedge clk);
        if (error_count == 0 && digest_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
